[design/process_slot_table_defines.svh]
// Assertion macros for the process slot table.
`ifndef PROCESS_SLOT_TABLE_DEFINES_SVH
`define PROCESS_SLOT_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// cond must never hold outside reset
`define PST_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("process_slot_table: forbidden condition seen");

// trig implies prop in the same cycle
`define PST_ASSERT_IMPLIES(lbl, trig, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
    else $error("process_slot_table: implication failed");

// trig implies prop in the next cycle
`define PST_ASSERT_NEXT(lbl, trig, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error("process_slot_table: next-cycle implication failed");

`else

`define PST_ASSERT_NEVER(lbl, cond)
`define PST_ASSERT_IMPLIES(lbl, trig, prop)
`define PST_ASSERT_NEXT(lbl, trig, prop)

`endif

`endif

[design/pst_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the process slot table.
package pst_pkg;

  localparam int OP_W           = 3;
  localparam int ID_W           = 31;
  localparam int IDX_W          = 5;
  localparam int TIME_W         = 64;
  localparam int COUNT_W        = 6;
  localparam int SLOT_COUNT_DEF = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOCATE = 3'd0,
    OP_FREE     = 3'd1,
    OP_FIND     = 3'd2,
    OP_SET_WAKE = 3'd3,
    OP_UNBLOCK  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // request token walking down the row of slot cells
  typedef struct packed {
    logic              live;
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   ext_id;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] tv;
    logic              found;
    logic [IDX_W-1:0]  slot;
  } token_t;

endpackage

[design/pst_cell.sv]
`timescale 1ns / 1ps
// One slot of the table: occupancy, stored id and wake time, plus a token stage.
module pst_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  pst_pkg::token_t tok_in,
  output pst_pkg::token_t tok_out,
  output logic            occupied
);

  localparam int IdxW = pst_pkg::IDX_W;
  localparam logic [IdxW-1:0] CellSlot = IdxW'(CELL_INDEX);
  // slots beyond the reach of the index field can never be addressed directly
  localparam bit Addressable = CELL_INDEX < (1 << IdxW);

  logic                        occ;
  logic [pst_pkg::ID_W-1:0]    slot_id;
  logic [pst_pkg::TIME_W-1:0]  wake;
  logic                        idx_match;
  logic                        hit;
  pst_pkg::token_t             tok_next;

  assign idx_match = Addressable && (tok_in.idx == CellSlot);
  assign occupied  = occ;

  always_comb begin
    hit = 1'b0;
    case (tok_in.op)
      pst_pkg::OP_ALLOCATE: hit = !tok_in.found && !occ;
      pst_pkg::OP_FREE:     hit = idx_match && occ;
      pst_pkg::OP_FIND:     hit = !tok_in.found && occ && (slot_id == tok_in.ext_id);
      pst_pkg::OP_SET_WAKE: hit = idx_match && occ;
      pst_pkg::OP_UNBLOCK:  hit = !tok_in.found && occ && (wake != '0) && (wake <= tok_in.tv);
      default:              hit = 1'b0;
    endcase
    hit = hit && tok_in.live;
  end

  always_comb begin
    tok_next = tok_in;
    if (hit) begin
      tok_next.found = 1'b1;
      tok_next.slot  = CellSlot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.live <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (hit) begin
      if (tok_in.op == pst_pkg::OP_ALLOCATE) begin
        occ <= 1'b1;
      end else if (tok_in.op == pst_pkg::OP_FREE) begin
        occ <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      case (tok_in.op)
        pst_pkg::OP_ALLOCATE: begin
          slot_id <= tok_in.ext_id;
          wake    <= '0;
        end
        pst_pkg::OP_SET_WAKE: wake <= tok_in.tv;
        pst_pkg::OP_UNBLOCK:  wake <= '0;
        default: ;
      endcase
    end
  end

endmodule

[design/process_slot_table.sv]
`timescale 1ns / 1ps
// Process slot table: top level with request head, row of slot cells and result register.
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------------
//  in      | in_valid / in_ready   | opcode, external_id, slot_index, time_value
//  out     | out_valid / out_ready | result_slot, ok, occupied_count, table_full
//
// From acceptance to result valid, a request goes through the head register, which loads
// at the accepting edge, then the register of each slot cell in turn, then the result register.
// One request is in the table at a time, so a new request is taken only after the result
// of the last one has been loaded into the output register.
// Reset clears occupancy, count and all valids; stored ids and wake times are not cleared.
// A result that finds the output register still full is parked, and in_ready stays low
// until it has moved into the output register.
`include "process_slot_table_defines.svh"
module process_slot_table #(
  parameter int SLOT_COUNT = pst_pkg::SLOT_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pst_pkg::OP_W-1:0]          opcode,
  input  logic [pst_pkg::ID_W-1:0]          external_id,
  input  logic [pst_pkg::IDX_W-1:0]         slot_index,
  input  logic [pst_pkg::TIME_W-1:0]        time_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pst_pkg::IDX_W-1:0]         result_slot,
  output logic                              ok,
  output logic [pst_pkg::COUNT_W-1:0]       occupied_count,
  output logic                              table_full
);

  localparam int CntW = $clog2(SLOT_COUNT + 1);
  localparam logic [CntW-1:0] FullCount = CntW'(SLOT_COUNT);

  pst_pkg::state_t state, state_next;
  pst_pkg::token_t head;
  pst_pkg::token_t tok [SLOT_COUNT+1];
  logic [SLOT_COUNT-1:0] occ_vec;

  logic [CntW-1:0] count, count_next;
  pst_pkg::token_t done_tok;
  logic            chain_done;
  logic            out_free;
  logic            accept;
  logic            load_from_chain;
  logic            load_from_fin;
  logic            park;

  logic [pst_pkg::IDX_W-1:0]   fin_slot;
  logic                        fin_ok;
  logic [pst_pkg::COUNT_W-1:0] fin_count;
  logic                        fin_full;

  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign done_tok   = tok[SLOT_COUNT];
  assign chain_done = done_tok.live;

  // head register launches the request into the row
  always_ff @(posedge clk) begin
    if (rst) begin
      head.live <= 1'b0;
    end else begin
      head.live   <= accept;
      head.op     <= opcode;
      head.ext_id <= external_id;
      head.idx    <= slot_index;
      head.tv     <= time_value;
      head.found  <= 1'b0;
      head.slot   <= '0;
    end
  end

  assign tok[0] = head;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    pst_cell #(
      .CELL_INDEX(g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1]),
      .occupied(occ_vec[g])
    );
  end

  always_comb begin
    count_next = count;
    if (chain_done && done_tok.found) begin
      if (done_tok.op == pst_pkg::OP_ALLOCATE) begin
        count_next = count + CntW'(1);
      end else if (done_tok.op == pst_pkg::OP_FREE) begin
        count_next = count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pst_pkg::ST_IDLE:  if (accept) state_next = pst_pkg::ST_RUN;
      pst_pkg::ST_RUN:   if (chain_done) state_next = out_free ? pst_pkg::ST_IDLE
                                                              : pst_pkg::ST_DRAIN;
      pst_pkg::ST_DRAIN: if (out_free) state_next = pst_pkg::ST_IDLE;
      default:           state_next = pst_pkg::ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_ready        = 1'b0;
    load_from_chain = 1'b0;
    load_from_fin   = 1'b0;
    park            = 1'b0;
    case (state)
      pst_pkg::ST_IDLE: in_ready = 1'b1;
      pst_pkg::ST_RUN: begin
        load_from_chain = chain_done && out_free;
        park            = chain_done && !out_free;
      end
      pst_pkg::ST_DRAIN: load_from_fin = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // parked result while the output is stalled
  always_ff @(posedge clk) begin
    if (park) begin
      fin_slot  <= done_tok.slot;
      fin_ok    <= done_tok.found;
      fin_count <= pst_pkg::COUNT_W'(count_next);
      fin_full  <= (count_next == FullCount);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_from_chain || load_from_fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_from_chain) begin
      result_slot    <= done_tok.slot;
      ok             <= done_tok.found;
      occupied_count <= pst_pkg::COUNT_W'(count_next);
      table_full     <= (count_next == FullCount);
    end else if (load_from_fin) begin
      result_slot    <= fin_slot;
      ok             <= fin_ok;
      occupied_count <= fin_count;
      table_full     <= fin_full;
    end
  end

  `PST_ASSERT_IMPLIES(a_exit_in_run, chain_done, state == pst_pkg::ST_RUN)
  `PST_ASSERT_NEVER(a_count_range, count > FullCount)
  `PST_ASSERT_NEXT(a_accept_launch, accept, head.live && state == pst_pkg::ST_RUN)
  `PST_ASSERT_IMPLIES(a_count_matches, state == pst_pkg::ST_IDLE, $countones(occ_vec) == int'(count))

endmodule

[dv/process_slot_table_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the process slot table: directed and random requests.
module process_slot_table_tb;
  import pst_pkg::*;

  localparam int SLOTS          = SLOT_COUNT_DEF;
  localparam int MAX_WAIT       = 11;
  localparam int IDLE_LIMIT     = 2000;
  localparam int SETTLE_CYCLES  = SLOTS + 20;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS    = 200;
  localparam int PHASES         = 6;
  localparam int ID_POOL        = 8;
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    bit [IDX_W-1:0]   slot;
    bit               ok;
    bit [COUNT_W-1:0] count;
    bit               full;
  } slot_result_t;

  class slot_table_scoreboard;
    bit [SLOTS-1:0]  occupancy;
    int unsigned     occupied;
    bit [ID_W-1:0]   ids   [SLOTS];
    bit [TIME_W-1:0] wakes [SLOTS];
    slot_result_t    expected_q [$];
    int              errors;

    function void note_request(bit [OP_W-1:0] op, bit [ID_W-1:0] id,
                               bit [IDX_W-1:0] idx, bit [TIME_W-1:0] tv);
      slot_result_t r;
      r.slot = '0;
      r.ok   = 1'b0;
      case (op)
        OP_ALLOCATE: begin
          if (occupied < SLOTS) begin
            for (int i = 0; i < SLOTS && !r.ok; i++) begin
              if (!occupancy[i]) begin
                occupancy[i] = 1'b1;
                ids[i]       = id;
                wakes[i]     = '0;
                occupied++;
                r.slot = IDX_W'(i);
                r.ok   = 1'b1;
              end
            end
          end
        end
        OP_FREE: begin
          if (idx < SLOTS && occupancy[idx]) begin
            occupancy[idx] = 1'b0;
            occupied--;
            r.slot = idx;
            r.ok   = 1'b1;
          end
        end
        OP_FIND: begin
          for (int i = 0; i < SLOTS && !r.ok; i++) begin
            if (occupancy[i] && ids[i] == id) begin
              r.slot = IDX_W'(i);
              r.ok   = 1'b1;
            end
          end
        end
        OP_SET_WAKE: begin
          if (idx < SLOTS && occupancy[idx]) begin
            wakes[idx] = tv;
            r.slot = idx;
            r.ok   = 1'b1;
          end
        end
        OP_UNBLOCK: begin
          for (int i = 0; i < SLOTS && !r.ok; i++) begin
            if (occupancy[i] && wakes[i] != '0 && wakes[i] <= tv) begin
              wakes[i] = '0;
              r.slot = IDX_W'(i);
              r.ok   = 1'b1;
            end
          end
        end
        default: ;
      endcase
      r.count = occupied[COUNT_W-1:0];
      r.full  = (occupied == SLOTS);
      expected_q.push_back(r);
    endfunction

    function void check_result(bit [IDX_W-1:0] got_slot, bit got_ok,
                               bit [COUNT_W-1:0] got_count, bit got_full);
      slot_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: slot %0d ok %0b count %0d full %0b",
                 $time, got_slot, got_ok, got_count, got_full);
        return;
      end
      want = expected_q.pop_front();
      if (want.slot != got_slot) begin
        errors++;
        $display("%0t: result_slot expected %0d actual %0d", $time, want.slot, got_slot);
      end
      if (want.ok != got_ok) begin
        errors++;
        $display("%0t: ok expected %0b actual %0b", $time, want.ok, got_ok);
      end
      if (want.count != got_count) begin
        errors++;
        $display("%0t: occupied_count expected %0d actual %0d", $time, want.count, got_count);
      end
      if (want.full != got_full) begin
        errors++;
        $display("%0t: table_full expected %0b actual %0b", $time, want.full, got_full);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // random allocated slot, -1 when the table is empty
    function int random_used_slot();
      int start;
      if (occupied == 0) return -1;
      start = $urandom_range(0, SLOTS - 1);
      for (int k = 0; k < SLOTS; k++) begin
        if (occupancy[(start + k) % SLOTS]) return (start + k) % SLOTS;
      end
      return -1;
    endfunction
  endclass

  logic               clk            = 1'b0;
  logic               rst            = 1'b1;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    opcode         = '0;
  logic [ID_W-1:0]    external_id    = '0;
  logic [IDX_W-1:0]   slot_index     = '0;
  logic [TIME_W-1:0]  time_value     = '0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic [IDX_W-1:0]   result_slot;
  logic               ok;
  logic [COUNT_W-1:0] occupied_count;
  logic               table_full;

  slot_table_scoreboard sb = new();

  bit              tx_quiet    = 1'b0;
  bit              rx_quiet    = 1'b0;
  int              rx_hold     = 0;
  int              idle_cycles = 0;
  bit [TIME_W-1:0] sim_now     = 1;
  bit [ID_W-1:0]   id_pool [ID_POOL];
  int              alloc_mix [PHASES] = '{50, 80, 20, 35, 15, 45};
  int              free_mix  [PHASES] = '{10,  5, 35, 20, 45, 20};

  process_slot_table uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .external_id    (external_id),
    .slot_index     (slot_index),
    .time_value     (time_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_slot    (result_slot),
    .ok             (ok),
    .occupied_count (occupied_count),
    .table_full     (table_full)
  );

  always #5 clk = ~clk;

  // returns at the edge on which the request was accepted
  task automatic drive_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                               input logic [IDX_W-1:0] idx, input logic [TIME_W-1:0] tv);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    external_id <= id;
    slot_index  <= idx;
    time_value  <= tv;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, id, idx, tv);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic random_request(input int alloc_pct, input int free_pct);
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   id;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] tv;
    int                roll;
    int                used;
    roll = $urandom_range(0, 99);
    if (roll < alloc_pct) op = OP_ALLOCATE;
    else if (roll < alloc_pct + free_pct) op = OP_FREE;
    else if (roll < 97) op = OP_W'(OP_FIND + $urandom_range(0, 2));
    else op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));

    used = sb.random_used_slot();
    // pool ids collide on purpose so find sees duplicates
    roll = $urandom_range(0, 9);
    if (roll < 4 && used >= 0) id = sb.ids[used];
    else if (roll < 8) id = id_pool[$urandom_range(0, ID_POOL - 1)];
    else id = ID_W'($urandom());

    if (used >= 0 && $urandom_range(0, 3) != 0) idx = IDX_W'(used);
    else idx = IDX_W'($urandom_range(0, SLOTS - 1));

    // a slowly rising clock keeps wake times within reach of unblock
    roll = $urandom_range(0, 9);
    if (roll == 0) tv = {$urandom(), $urandom()};
    else if (roll == 1) tv = '0;
    else if (op == OP_SET_WAKE) tv = sim_now + $urandom_range(1, 60);
    else tv = sim_now;
    sim_now += $urandom_range(0, 8);

    drive_request(op, id, idx, tv);
  endtask

  // result side
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(result_slot, ok, occupied_count, table_full);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < ID_POOL; i++) id_pool[i] = ID_W'($urandom());

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty table: every lookup misses, every slot op is refused
    drive_request(OP_FIND,     '0, '0, '0);
    drive_request(OP_UNBLOCK,  '0, '0, '1);
    drive_request(OP_FREE,     '0, '0, '0);
    drive_request(OP_SET_WAKE, '1, '1, '1);
    drive_request(OP_SPARE_LO, '0, '0, '0);
    drive_request(OP_W'(OP_SPARE_LO + 1), '1, '0, '1);
    drive_request(OP_SPARE_HI, '1, '1, '1);
    // id extremes, then wake times at both ends
    drive_request(OP_ALLOCATE, '0, '1, '1);
    drive_request(OP_ALLOCATE, '1, '0, '0);
    drive_request(OP_FIND,     '1, '0, '0);
    drive_request(OP_SET_WAKE, '0, IDX_W'(0), '1);
    drive_request(OP_SET_WAKE, '0, IDX_W'(1), TIME_W'(1));
    drive_request(OP_UNBLOCK,  '0, '0, '0);
    drive_request(OP_UNBLOCK,  '0, '0, TIME_W'(1));
    drive_request(OP_UNBLOCK,  '0, '0, '1);
    drive_request(OP_UNBLOCK,  '0, '0, '1);
    // zero wake time means not waiting
    drive_request(OP_SET_WAKE, '0, IDX_W'(0), '0);
    drive_request(OP_UNBLOCK,  '0, '0, '1);
    // double free, and a freed slot drops out of find
    drive_request(OP_FREE,     '0, IDX_W'(1), '0);
    drive_request(OP_FREE,     '0, IDX_W'(1), '0);
    drive_request(OP_FIND,     '1, '0, '0);
    drive_request(OP_ALLOCATE, ID_W'($urandom()), '0, '0);
    drain_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      tx_quiet = (phase == 2 || phase == 4);
      rx_quiet = (phase == 2 || phase == 4);
      // long result stall so the table backs up onto its input
      if (phase == 3) rx_hold = RX_HOLD_CYCLES;
      repeat (PHASE_ITEMS) random_request(alloc_mix[phase], free_mix[phase]);
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/pst_pkg.sv
design/pst_cell.sv
design/process_slot_table.sv
dv/process_slot_table_tb.sv
